/* rtl/dwsp_pkg.sv */
// Shared types, constants and the control program of the wheel speed PID block.
package dwsp_pkg;

	// Field and datapath widths
	localparam int TGT_W    = 13;
	localparam int STEER_W  = 16;
	localparam int GAIN_W   = 24;
	localparam int COEF_W   = 23;
	localparam int MUL_W    = 25;
	localparam int PROD_W   = 2 * MUL_W;
	localparam int ACC_W    = PROD_W + 1;
	localparam int SET_W    = 29;
	localparam int DIFF_W   = 30;
	localparam int ERR_W    = 24;
	localparam int DERR_W   = ERR_W + 1;
	localparam int INTEG_W  = 24;
	localparam int DRIVE_W  = 20;
	localparam int DSUM_W   = ACC_W - 16 + 1;
	localparam int RAMP_W   = 16;
	localparam int DUTY_W   = 10;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 24;

	// Control constants
	localparam int BAND_OUTER = 120;
	localparam int BAND_INNER = 40;
	localparam int UNITY      = 65536;
	localparam int INTEG_LIM  = 1280000;
	localparam int DRIVE_LIM  = 256000;
	localparam int DUTY_LIM   = 990;
	localparam int RAMP_START = 12800;
	localparam int RAMP_FLOOR = 5120;
	localparam int RAMP_STEP  = 77;
	localparam int ERR_MAX    = 8388607;
	localparam int ERR_MIN    = -8388608;

	// Register reset values
	localparam int GAIN_P_RST = 393216;
	localparam int GAIN_I_RST = 20;
	localparam int GAIN_D_RST = 137626;
	localparam int CENTER_RST = 0;
	localparam int SLOPE_RST  = 138;
	localparam int CAP_RST    = 16056;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_P = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_I = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_D = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SLOPE  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CAP    = 3'd5;

	// Program layout
	localparam int PROG_LEN = 21;
	localparam int STEP_W   = $clog2(PROG_LEN);
	typedef logic [STEP_W-1:0] step_t;

	localparam step_t STEP_WAIT   = STEP_W'(0);
	localparam step_t STEP_STEER  = STEP_W'(1);
	localparam step_t STEP_WHEEL0 = STEP_W'(6);
	localparam step_t STEP_WHEEL1 = STEP_W'(13);
	localparam step_t STEP_OUT    = STEP_W'(20);

	typedef enum logic [3:0] {
		OP_WAIT,
		OP_STEER,
		OP_COEF,
		OP_MDOWN,
		OP_MUP,
		OP_SUP,
		OP_ERR,
		OP_INTEG,
		OP_MULP,
		OP_MULI,
		OP_MULD,
		OP_ACC,
		OP_DRIVE,
		OP_OUT
	} op_t;

	typedef enum logic [2:0] {
		BR_NEXT,
		BR_WAIT_IN,
		BR_IF_STOP,
		BR_OUT,
		BR_JUMP
	} br_t;

	typedef struct packed {
		op_t  op;
		logic wheel;
	} ctrl_t;

	typedef struct packed {
		ctrl_t ctrl;
		br_t   br;
		step_t tgt;
	} cw_t;

	typedef struct packed {
		logic [GAIN_W-1:0]  gain_p;
		logic [GAIN_W-1:0]  gain_i;
		logic [GAIN_W-1:0]  gain_d;
		logic [STEER_W-1:0] steer_center;
		logic [STEER_W-1:0] diff_slope;
		logic [STEER_W-1:0] diff_cap;
	} cfg_t;

	typedef struct packed {
		logic signed [TGT_W-1:0] target_speed;
		logic [STEER_W-1:0]      steer_duty;
		logic signed [TGT_W-1:0] left_measured;
		logic signed [TGT_W-1:0] right_measured;
		logic                    stop_request;
	} item_t;

	typedef struct packed {
		logic [DUTY_W-1:0] left_forward;
		logic [DUTY_W-1:0] left_reverse;
		logic [DUTY_W-1:0] right_forward;
		logic [DUTY_W-1:0] right_reverse;
	} duty_t;

	function automatic cw_t mk(input op_t op, input logic wheel, input br_t br,
		input step_t tgt);
		cw_t w;
		w.ctrl.op    = op;
		w.ctrl.wheel = wheel;
		w.br         = br;
		w.tgt        = tgt;
		return w;
	endfunction

	// Control store: one word per step
	function automatic cw_t rom_word(input step_t s);
		cw_t w;
		case (s)
			5'd0:    w = mk(OP_WAIT,  1'b0, BR_WAIT_IN, STEP_WAIT);
			5'd1:    w = mk(OP_STEER, 1'b0, BR_IF_STOP, STEP_WHEEL0);
			5'd2:    w = mk(OP_COEF,  1'b0, BR_NEXT,    STEP_WAIT);
			5'd3:    w = mk(OP_MDOWN, 1'b0, BR_NEXT,    STEP_WAIT);
			5'd4:    w = mk(OP_MUP,   1'b0, BR_NEXT,    STEP_WAIT);
			5'd5:    w = mk(OP_SUP,   1'b0, BR_NEXT,    STEP_WAIT);
			5'd6:    w = mk(OP_ERR,   1'b0, BR_NEXT,    STEP_WAIT);
			5'd7:    w = mk(OP_INTEG, 1'b0, BR_NEXT,    STEP_WAIT);
			5'd8:    w = mk(OP_MULP,  1'b0, BR_NEXT,    STEP_WAIT);
			5'd9:    w = mk(OP_MULI,  1'b0, BR_NEXT,    STEP_WAIT);
			5'd10:   w = mk(OP_MULD,  1'b0, BR_NEXT,    STEP_WAIT);
			5'd11:   w = mk(OP_ACC,   1'b0, BR_NEXT,    STEP_WAIT);
			5'd12:   w = mk(OP_DRIVE, 1'b0, BR_JUMP,    STEP_WHEEL1);
			5'd13:   w = mk(OP_ERR,   1'b1, BR_NEXT,    STEP_WAIT);
			5'd14:   w = mk(OP_INTEG, 1'b1, BR_NEXT,    STEP_WAIT);
			5'd15:   w = mk(OP_MULP,  1'b1, BR_NEXT,    STEP_WAIT);
			5'd16:   w = mk(OP_MULI,  1'b1, BR_NEXT,    STEP_WAIT);
			5'd17:   w = mk(OP_MULD,  1'b1, BR_NEXT,    STEP_WAIT);
			5'd18:   w = mk(OP_ACC,   1'b1, BR_NEXT,    STEP_WAIT);
			5'd19:   w = mk(OP_DRIVE, 1'b1, BR_JUMP,    STEP_OUT);
			5'd20:   w = mk(OP_OUT,   1'b0, BR_OUT,     STEP_WAIT);
			default: w = mk(OP_WAIT,  1'b0, BR_JUMP,    STEP_WAIT);
		endcase
		return w;
	endfunction

endpackage

/* rtl/dwsp_datapath.sv */
// Datapath of the wheel speed PID: shared multiplier, accumulator and wheel state.
module dwsp_datapath import dwsp_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  ctrl_t ctrl,
	input  cfg_t  cfg,
	input  item_t item,
	output duty_t duty
);

	logic signed [STEER_W:0]   off;
	logic                      off_neg;
	logic [STEER_W-1:0]        mag;
	logic [COEF_W-1:0]         coef_nx;
	logic signed [MUL_W-1:0]   fac_dn;
	logic signed [MUL_W-1:0]   fac_up;
	logic signed [MUL_W-1:0]   mul_a;
	logic signed [MUL_W-1:0]   mul_b;
	logic signed [PROD_W-1:0]  mul_p;
	logic [RAMP_W-1:0]         ramp_nx;
	logic signed [SET_W-1:0]   set_sel;
	logic signed [TGT_W-1:0]   meas_sel;
	logic signed [DIFF_W-1:0]  diff;
	logic signed [ERR_W-1:0]   err_nx;
	logic signed [DERR_W-1:0]  isum;
	logic signed [DSUM_W-1:0]  dsum;
	logic signed [ACC_W-1:0]   acc_add;

	logic [COEF_W-1:0]         coef_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [SET_W-1:0]   down_q;
	logic signed [SET_W-1:0]   up_q;
	logic signed [ERR_W-1:0]   err_q;
	logic signed [DERR_W-1:0]  derr_q;
	logic [RAMP_W-1:0]         ramp_q;
	logic signed [ERR_W-1:0]   prev_q  [2];
	logic signed [INTEG_W-1:0] integ_q [2];
	logic signed [DRIVE_W-1:0] drive_q [2];

	// Steering offset and differential coefficient
	always_comb begin
		off     = $signed({1'b0, item.steer_duty}) - $signed({1'b0, cfg.steer_center});
		off_neg = off[STEER_W];
		mag     = off_neg ? STEER_W'(-off) : STEER_W'(off);
		if (mag > STEER_W'(BAND_OUTER))
			coef_nx = COEF_W'(cfg.diff_cap);
		else if (mag < STEER_W'(BAND_INNER))
			coef_nx = '0;
		else
			coef_nx = prod_q[COEF_W-1:0];
		fac_dn  = MUL_W'(UNITY) - $signed({2'b0, coef_q});
		fac_up  = MUL_W'(UNITY) + $signed({2'b0, coef_q});
		ramp_nx = (ramp_q < RAMP_W'(RAMP_FLOOR)) ? '0 : ramp_q - RAMP_W'(RAMP_STEP);
	end

	// Shared multiplier operand select
	always_comb begin
		case (ctrl.op)
			OP_STEER: begin
				mul_a = $signed({18'b0, mag[6:0]});
				mul_b = $signed({9'b0, cfg.diff_slope});
			end
			OP_MDOWN: begin
				mul_a = MUL_W'(item.target_speed);
				mul_b = fac_dn;
			end
			OP_MUP: begin
				mul_a = MUL_W'(item.target_speed);
				mul_b = fac_up;
			end
			OP_MULP: begin
				mul_a = MUL_W'(err_q);
				mul_b = $signed({1'b0, cfg.gain_p});
			end
			OP_MULI: begin
				mul_a = MUL_W'(integ_q[ctrl.wheel]);
				mul_b = $signed({1'b0, cfg.gain_i});
			end
			OP_MULD: begin
				mul_a = derr_q;
				mul_b = $signed({1'b0, cfg.gain_d});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

	// Per-wheel error, integral and drive update
	always_comb begin
		if (ctrl.wheel == 1'b0) begin
			set_sel  = off_neg ? up_q : down_q;
			meas_sel = item.left_measured;
		end else begin
			set_sel  = off_neg ? down_q : up_q;
			meas_sel = item.right_measured;
		end
		diff = DIFF_W'(set_sel) - DIFF_W'($signed({meas_sel, 8'b0}));
		if (diff > DIFF_W'(ERR_MAX))
			err_nx = ERR_W'(ERR_MAX);
		else if (diff < DIFF_W'(ERR_MIN))
			err_nx = ERR_W'(ERR_MIN);
		else
			err_nx = ERR_W'(diff);
		isum    = DERR_W'(integ_q[ctrl.wheel]) + DERR_W'(err_q);
		acc_add = acc_q + ACC_W'(prod_q);
		dsum    = DSUM_W'(drive_q[ctrl.wheel]) + DSUM_W'(acc_q >>> 16);
	end

	always_ff @(posedge clk) begin
		case (ctrl.op)
			OP_STEER: begin
				prod_q <= mul_p;
				if (item.stop_request) begin
					down_q <= $signed({13'b0, ramp_nx});
					up_q   <= $signed({13'b0, ramp_nx});
				end
			end
			OP_COEF:  coef_q <= coef_nx;
			OP_MDOWN: prod_q <= mul_p;
			OP_MUP: begin
				down_q <= SET_W'(prod_q >>> 8);
				prod_q <= mul_p;
			end
			OP_SUP:   up_q <= SET_W'(prod_q >>> 8);
			OP_ERR:   err_q <= err_nx;
			OP_INTEG: derr_q <= DERR_W'(err_q) - DERR_W'(prev_q[ctrl.wheel]);
			OP_MULP:  prod_q <= mul_p;
			OP_MULI: begin
				acc_q  <= ACC_W'(prod_q);
				prod_q <= mul_p;
			end
			OP_MULD: begin
				acc_q  <= acc_add;
				prod_q <= mul_p;
			end
			OP_ACC:   acc_q <= acc_add;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ramp_q     <= RAMP_W'(RAMP_START);
			prev_q[0]  <= '0;
			prev_q[1]  <= '0;
			integ_q[0] <= '0;
			integ_q[1] <= '0;
			drive_q[0] <= '0;
			drive_q[1] <= '0;
		end else begin
			case (ctrl.op)
				OP_STEER: begin
					if (item.stop_request)
						ramp_q <= ramp_nx;
				end
				OP_INTEG: begin
					prev_q[ctrl.wheel] <= err_q;
					if (isum > DERR_W'(INTEG_LIM))
						integ_q[ctrl.wheel] <= INTEG_W'(INTEG_LIM);
					else if (isum < -DERR_W'(INTEG_LIM))
						integ_q[ctrl.wheel] <= -INTEG_W'(INTEG_LIM);
					else
						integ_q[ctrl.wheel] <= INTEG_W'(isum);
				end
				OP_DRIVE: begin
					if (dsum > DSUM_W'(DRIVE_LIM))
						drive_q[ctrl.wheel] <= DRIVE_W'(DRIVE_LIM);
					else if (dsum < -DSUM_W'(DRIVE_LIM))
						drive_q[ctrl.wheel] <= -DRIVE_W'(DRIVE_LIM);
					else
						drive_q[ctrl.wheel] <= DRIVE_W'(dsum);
				end
				default: ;
			endcase
		end
	end

	// Truncate drive toward zero, clamp and split by direction
	logic [DRIVE_W-1:0] dmag [2];
	logic [DRIVE_W-9:0] dq   [2];
	logic [DUTY_W-1:0]  dc   [2];
	logic [DUTY_W-1:0]  fwd  [2];
	logic [DUTY_W-1:0]  rev  [2];

	always_comb begin
		for (int i = 0; i < 2; i++) begin
			dmag[i] = drive_q[i][DRIVE_W-1] ? DRIVE_W'(-drive_q[i]) : DRIVE_W'(drive_q[i]);
			dq[i]   = dmag[i][DRIVE_W-1:8];
			dc[i]   = (dq[i] > (DRIVE_W-8)'(DUTY_LIM)) ? DUTY_W'(DUTY_LIM) : DUTY_W'(dq[i]);
			fwd[i]  = drive_q[i][DRIVE_W-1] ? '0 : dc[i];
			rev[i]  = drive_q[i][DRIVE_W-1] ? dc[i] : '0;
		end
		duty.left_forward  = fwd[0];
		duty.left_reverse  = rev[0];
		duty.right_forward = fwd[1];
		duty.right_reverse = rev[1];
	end

	a_integ_lim: assert property (@(posedge clk) disable iff (!arst_n)
		integ_q[0] <= INTEG_W'(INTEG_LIM) && integ_q[0] >= -INTEG_W'(INTEG_LIM)
		&& integ_q[1] <= INTEG_W'(INTEG_LIM) && integ_q[1] >= -INTEG_W'(INTEG_LIM))
		else $error("integral beyond limit");

	a_drive_lim: assert property (@(posedge clk) disable iff (!arst_n)
		drive_q[0] <= DRIVE_W'(DRIVE_LIM) && drive_q[0] >= -DRIVE_W'(DRIVE_LIM)
		&& drive_q[1] <= DRIVE_W'(DRIVE_LIM) && drive_q[1] >= -DRIVE_W'(DRIVE_LIM))
		else $error("drive beyond limit");

	a_ramp: assert property (@(posedge clk) disable iff (!arst_n)
		ramp_q == '0 || ramp_q >= RAMP_W'(RAMP_FLOOR - RAMP_STEP))
		else $error("stop ramp left its range");

	a_ramp_move: assert property (@(posedge clk) disable iff (!arst_n)
		ramp_q != $past(ramp_q) |-> $past(ctrl.op) == OP_STEER && $past(item.stop_request))
		else $error("stop ramp moved outside a stop tick");

endmodule

/* rtl/differential_wheel_speed_pid_top.sv */
// An accepted word runs the steering step, then both wheels, then the output step;
// stop mode skips the coefficient and setpoint steps. One shared 25x25 multiplier,
// stepped by a 21-word microprogram, means a new word is taken only at the wait step.
// A new word is taken while the previous result still waits at the output.
// Reset clears wheel state and drives, loads the stop ramp with 50.0 and
// loads every register with its default; no clearing pass is needed.
module differential_wheel_speed_pid_top import dwsp_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic signed [TGT_W-1:0]     target_speed,
	input  logic [STEER_W-1:0]          steer_duty,
	input  logic signed [TGT_W-1:0]     left_measured,
	input  logic signed [TGT_W-1:0]     right_measured,
	input  logic                        stop_request,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [DUTY_W-1:0]           left_forward_duty,
	output logic [DUTY_W-1:0]           left_reverse_duty,
	output logic [DUTY_W-1:0]           right_forward_duty,
	output logic [DUTY_W-1:0]           right_reverse_duty,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [CFG_DATA_W-1:0]       cfg_data
);

	step_t  step_q;
	step_t  step_nx;
	cw_t    cw;
	cfg_t   cfg_q;
	item_t  item_q;
	duty_t  duty_d;
	duty_t  duty_q;
	logic   out_valid_q;
	logic   in_accept;
	logic   out_blocked;
	logic   out_fire;

	assign cw          = rom_word(step_q);
	assign in_stall    = (cw.br != BR_WAIT_IN);
	assign in_accept   = in_valid && !in_stall;
	assign out_blocked = out_valid_q && out_stall;
	assign out_fire    = out_valid_q && !out_stall;
	assign cfg_ready   = 1'b1;

	// Sequencer next step
	always_comb begin
		case (cw.br)
			BR_NEXT:    step_nx = step_q + STEP_W'(1);
			BR_WAIT_IN: step_nx = in_accept ? step_q + STEP_W'(1) : step_q;
			BR_IF_STOP: step_nx = item_q.stop_request ? cw.tgt : step_q + STEP_W'(1);
			BR_OUT:     step_nx = out_blocked ? step_q : cw.tgt;
			BR_JUMP:    step_nx = cw.tgt;
			default:    step_nx = STEP_WAIT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			step_q <= STEP_WAIT;
		else
			step_q <= step_nx;
	end

	// Capture the input word
	always_ff @(posedge clk) begin
		if (in_accept) begin
			item_q.target_speed   <= target_speed;
			item_q.steer_duty     <= steer_duty;
			item_q.left_measured  <= left_measured;
			item_q.right_measured <= right_measured;
			item_q.stop_request   <= stop_request;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_p       <= GAIN_W'(GAIN_P_RST);
			cfg_q.gain_i       <= GAIN_W'(GAIN_I_RST);
			cfg_q.gain_d       <= GAIN_W'(GAIN_D_RST);
			cfg_q.steer_center <= STEER_W'(CENTER_RST);
			cfg_q.diff_slope   <= STEER_W'(SLOPE_RST);
			cfg_q.diff_cap     <= STEER_W'(CAP_RST);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_GAIN_P: cfg_q.gain_p       <= cfg_data;
				REG_GAIN_I: cfg_q.gain_i       <= cfg_data;
				REG_GAIN_D: cfg_q.gain_d       <= cfg_data;
				REG_CENTER: cfg_q.steer_center <= cfg_data[STEER_W-1:0];
				REG_SLOPE:  cfg_q.diff_slope   <= cfg_data[STEER_W-1:0];
				REG_CAP:    cfg_q.diff_cap     <= cfg_data[STEER_W-1:0];
				default: ;
			endcase
		end
	end

	dwsp_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (cw.ctrl),
		.cfg    (cfg_q),
		.item   (item_q),
		.duty   (duty_d)
	);

	// Output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cw.ctrl.op == OP_OUT && !out_blocked)
			out_valid_q <= 1'b1;
		else if (out_fire)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cw.ctrl.op == OP_OUT && !out_blocked)
			duty_q <= duty_d;
	end

	assign out_valid          = out_valid_q;
	assign left_forward_duty  = duty_q.left_forward;
	assign left_reverse_duty  = duty_q.left_reverse;
	assign right_forward_duty = duty_q.right_forward;
	assign right_reverse_duty = duty_q.right_reverse;

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q < STEP_W'(PROG_LEN))
		else $error("step counter beyond program");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> step_q == STEP_STEER)
		else $error("accepted word did not start the program");

	a_out_from_prog: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cw.ctrl.op) == OP_OUT)
		else $error("result raised outside the output step");

	a_one_dir: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (duty_q.left_forward == '0 || duty_q.left_reverse == '0)
		&& (duty_q.right_forward == '0 || duty_q.right_reverse == '0))
		else $error("both directions driven");

	a_duty_lim: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> duty_q.left_forward <= DUTY_W'(DUTY_LIM)
		&& duty_q.left_reverse <= DUTY_W'(DUTY_LIM)
		&& duty_q.right_forward <= DUTY_W'(DUTY_LIM)
		&& duty_q.right_reverse <= DUTY_W'(DUTY_LIM))
		else $error("duty beyond limit");

endmodule
